FILE: rtl/dda_rast_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DDA line rasteriser package
// Shared widths, codes, state type and controller/datapath interface structs.
// ----------------------------------------------------------------------------
package dda_rast_pkg;

    localparam int COORD_W   = 20;
    localparam int REG_W     = 13;
    localparam int PIX_W     = 13;
    localparam int STEPS_W   = 13;
    localparam int CFG_IDX_W = 2;

    localparam int DEF_COORD_FRAC_BITS = 8;
    localparam int DEF_STEP_FRAC_BITS  = 16;

    localparam logic signed [REG_W-1:0] CLIP_HIGH_RESET = 13'sd1100;
    localparam logic signed [REG_W-1:0] CLIP_LOW_RESET  = -13'sd800;

    typedef enum logic
    {
        CMD_LOAD    = 1'b0,
        CMD_ADVANCE = 1'b1
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0]
    {
        REG_OFFSET_X  = 2'd0,
        REG_OFFSET_Y  = 2'd1,
        REG_CLIP_HIGH = 2'd2,
        REG_CLIP_LOW  = 2'd3
    } cfg_reg_t;

    typedef enum logic [3:0]
    {
        S_IDLE,
        S_DISPATCH,
        S_IDLE_ADV,
        S_ROUND,
        S_SPAN,
        S_PREP,
        S_DIV,
        S_FIN,
        S_ADD,
        S_CHECK
    } state_t;

    typedef enum logic [1:0]
    {
        EMIT_IDLE,
        EMIT_SINGLE,
        EMIT_LOAD,
        EMIT_STEP
    } emit_t;

    typedef struct packed
    {
        logic  capture;
        logic  do_round;
        logic  do_span;
        logic  do_prep;
        logic  div_step;
        logic  do_add;
        logic  emit;
        emit_t emit_kind;
    } dp_cmd_t;

    typedef struct packed
    {
        logic is_advance;
        logic run_active;
        logic span_zero;
        logic div_last;
        logic res_free;
    } dp_stat_t;

endpackage

FILE: rtl/dda_rast_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DDA rasteriser input channel
// Valid/ready channel carrying one command word with a segment.
// ----------------------------------------------------------------------------
interface dda_rast_in_if;

    logic                                       valid;
    logic                                       ready;
    dda_rast_pkg::cmd_t                         command;
    logic signed [dda_rast_pkg::COORD_W-1:0]    start_x;
    logic signed [dda_rast_pkg::COORD_W-1:0]    start_y;
    logic signed [dda_rast_pkg::COORD_W-1:0]    end_x;
    logic signed [dda_rast_pkg::COORD_W-1:0]    end_y;

    modport source (output valid, command, start_x, start_y, end_x, end_y, input ready);
    modport sink   (input valid, command, start_x, start_y, end_x, end_y, output ready);

endinterface

FILE: rtl/dda_rast_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DDA rasteriser output channel
// Valid/ready channel carrying one pixel result word.
// ----------------------------------------------------------------------------
interface dda_rast_out_if;

    logic                                   valid;
    logic                                   ready;
    logic                                   point_valid;
    logic signed [dda_rast_pkg::PIX_W-1:0]  pixel_x;
    logic signed [dda_rast_pkg::PIX_W-1:0]  pixel_y;
    logic                                   last;

    modport source (output valid, point_valid, pixel_x, pixel_y, last, input ready);
    modport sink   (input valid, point_valid, pixel_x, pixel_y, last, output ready);

endinterface

FILE: rtl/dda_rast_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DDA rasteriser configuration channel
// Valid/ready register write channel: index and data.
// ----------------------------------------------------------------------------
interface dda_rast_cfg_if;

    logic                                       valid;
    logic                                       ready;
    logic [dda_rast_pkg::CFG_IDX_W-1:0]         index;
    logic [dda_rast_pkg::REG_W-1:0]             data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);

endinterface

FILE: rtl/dda_rast_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DDA rasteriser controller
// Sequences capture, rounding, span, division, stepping and result issue.
// ----------------------------------------------------------------------------
module dda_rast_ctrl
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  dda_rast_pkg::dp_stat_t  stat,
    output dda_rast_pkg::dp_cmd_t   cmd
);

    dda_rast_pkg::state_t state_reg;
    dda_rast_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dda_rast_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            dda_rast_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = dda_rast_pkg::S_DISPATCH;
                end
            end
            dda_rast_pkg::S_DISPATCH:
            begin
                if (!stat.is_advance)
                begin
                    state_next = dda_rast_pkg::S_ROUND;
                end
                else if (stat.run_active)
                begin
                    state_next = dda_rast_pkg::S_ADD;
                end
                else
                begin
                    state_next = dda_rast_pkg::S_IDLE_ADV;
                end
            end
            dda_rast_pkg::S_IDLE_ADV:
            begin
                if (stat.res_free)
                begin
                    state_next = dda_rast_pkg::S_IDLE;
                end
            end
            dda_rast_pkg::S_ROUND:
            begin
                state_next = dda_rast_pkg::S_SPAN;
            end
            dda_rast_pkg::S_SPAN:
            begin
                state_next = dda_rast_pkg::S_PREP;
            end
            dda_rast_pkg::S_PREP:
            begin
                if (!stat.span_zero)
                begin
                    state_next = dda_rast_pkg::S_DIV;
                end
                else if (stat.res_free)
                begin
                    state_next = dda_rast_pkg::S_IDLE;
                end
            end
            dda_rast_pkg::S_DIV:
            begin
                if (stat.div_last)
                begin
                    state_next = dda_rast_pkg::S_FIN;
                end
            end
            dda_rast_pkg::S_FIN:
            begin
                if (stat.res_free)
                begin
                    state_next = dda_rast_pkg::S_IDLE;
                end
            end
            dda_rast_pkg::S_ADD:
            begin
                state_next = dda_rast_pkg::S_CHECK;
            end
            dda_rast_pkg::S_CHECK:
            begin
                if (stat.res_free)
                begin
                    state_next = dda_rast_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = dda_rast_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready      = 1'b0;
        cmd           = '0;
        cmd.emit_kind = dda_rast_pkg::EMIT_IDLE;
        case (state_reg)
            dda_rast_pkg::S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            dda_rast_pkg::S_DISPATCH:
            begin
            end
            dda_rast_pkg::S_IDLE_ADV:
            begin
                cmd.emit      = stat.res_free;
                cmd.emit_kind = dda_rast_pkg::EMIT_IDLE;
            end
            dda_rast_pkg::S_ROUND:
            begin
                cmd.do_round = 1'b1;
            end
            dda_rast_pkg::S_SPAN:
            begin
                cmd.do_span = 1'b1;
            end
            dda_rast_pkg::S_PREP:
            begin
                cmd.do_prep   = !stat.span_zero;
                cmd.emit      = stat.span_zero && stat.res_free;
                cmd.emit_kind = dda_rast_pkg::EMIT_SINGLE;
            end
            dda_rast_pkg::S_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            dda_rast_pkg::S_FIN:
            begin
                cmd.emit      = stat.res_free;
                cmd.emit_kind = dda_rast_pkg::EMIT_LOAD;
            end
            dda_rast_pkg::S_ADD:
            begin
                cmd.do_add = 1'b1;
            end
            dda_rast_pkg::S_CHECK:
            begin
                cmd.emit      = stat.res_free;
                cmd.emit_kind = dda_rast_pkg::EMIT_STEP;
            end
            default:
            begin
            end
        endcase
    end

endmodule

FILE: rtl/dda_rast_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DDA rasteriser datapath
// Config registers, rounding, span, shift-subtract dividers, accumulators,
// clip test and the output word register.
// ----------------------------------------------------------------------------
module dda_rast_dp
#(
    parameter int COORD_FRAC_BITS = dda_rast_pkg::DEF_COORD_FRAC_BITS,
    parameter int STEP_FRAC_BITS  = dda_rast_pkg::DEF_STEP_FRAC_BITS
)
(
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  dda_rast_pkg::dp_cmd_t                       cmd,
    output dda_rast_pkg::dp_stat_t                      stat,
    input  logic                                        cfg_we,
    input  logic [dda_rast_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [dda_rast_pkg::REG_W-1:0]              cfg_data,
    input  dda_rast_pkg::cmd_t                          in_command,
    input  logic signed [dda_rast_pkg::COORD_W-1:0]     in_start_x,
    input  logic signed [dda_rast_pkg::COORD_W-1:0]     in_start_y,
    input  logic signed [dda_rast_pkg::COORD_W-1:0]     in_end_x,
    input  logic signed [dda_rast_pkg::COORD_W-1:0]     in_end_y,
    input  logic                                        out_ready,
    output logic                                        out_valid,
    output logic                                        out_point_valid,
    output logic signed [dda_rast_pkg::PIX_W-1:0]       out_pixel_x,
    output logic signed [dda_rast_pkg::PIX_W-1:0]       out_pixel_y,
    output logic                                        out_last
);

    localparam int CW      = dda_rast_pkg::COORD_W;
    localparam int RW      = dda_rast_pkg::REG_W;
    localparam int PW      = dda_rast_pkg::PIX_W;
    localparam int STW     = dda_rast_pkg::STEPS_W;
    localparam bit SH_LEFT = STEP_FRAC_BITS >= COORD_FRAC_BITS;
    localparam int SH      = SH_LEFT ? STEP_FRAC_BITS - COORD_FRAC_BITS
                                     : COORD_FRAC_BITS - STEP_FRAC_BITS;
    localparam int SCL_W   = SH_LEFT ? CW + SH : CW;
    localparam int NUM_W   = SCL_W + 1;
    localparam int OFFS_W  = RW + STEP_FRAC_BITS;
    localparam int ACC_W   = ((NUM_W > OFFS_W) ? NUM_W : OFFS_W) + 2;
    localparam int RND_W   = CW - COORD_FRAC_BITS + 1;
    localparam int SPAN_W  = RND_W + 1;
    localparam int DVD_W   = NUM_W + 1;
    localparam int CNT_W   = $clog2(DVD_W);
    localparam int SUM_W   = ((RND_W > RW) ? RND_W : RW) + 1;

    localparam logic signed [CW:0]    HALF_C = (CW+1)'(1) << (COORD_FRAC_BITS - 1);
    localparam logic signed [ACC_W:0] HALF_S = (ACC_W+1)'(1) << (STEP_FRAC_BITS - 1);
    localparam logic [CNT_W-1:0]      CNT_TOP = CNT_W'(DVD_W - 1);

    // configuration
    logic signed [RW-1:0] offset_x_reg, offset_y_reg, clip_high_reg, clip_low_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_x_reg  <= '0;
            offset_y_reg  <= '0;
            clip_high_reg <= dda_rast_pkg::CLIP_HIGH_RESET;
            clip_low_reg  <= dda_rast_pkg::CLIP_LOW_RESET;
        end
        else if (cfg_we)
        begin
            case (dda_rast_pkg::cfg_reg_t'(cfg_index))
                dda_rast_pkg::REG_OFFSET_X:  offset_x_reg  <= cfg_data;
                dda_rast_pkg::REG_OFFSET_Y:  offset_y_reg  <= cfg_data;
                dda_rast_pkg::REG_CLIP_HIGH: clip_high_reg <= cfg_data;
                dda_rast_pkg::REG_CLIP_LOW:  clip_low_reg  <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    function automatic logic signed [RND_W-1:0] round_coord(input logic signed [CW-1:0] v);
        logic signed [CW:0] ve;
        logic signed [CW:0] nb;
        logic signed [CW:0] t;
        ve    = v;
        nb    = '0;
        nb[0] = v[CW-1];
        t     = ve + HALF_C - nb;
        t     = t >>> COORD_FRAC_BITS;
        return t[RND_W-1:0];
    endfunction

    function automatic logic signed [SCL_W-1:0] scale_coord(input logic signed [CW-1:0] v);
        logic signed [SCL_W-1:0] w;
        w = v;
        if (SH_LEFT)
        begin
            w = w <<< SH;
        end
        else
        begin
            w = w >>> SH;
        end
        return w;
    endfunction

    function automatic logic [NUM_W-1:0] scale_mag(input logic signed [CW:0] d);
        logic [CW:0]      a;
        logic [NUM_W-1:0] w;
        a = d[CW] ? CW'(1'b0) - d : d;
        w = NUM_W'(a);
        if (SH_LEFT)
        begin
            w = w << SH;
        end
        else
        begin
            w = w >> SH;
        end
        return w;
    endfunction

    function automatic logic [SPAN_W-1:0] abs_diff(input logic signed [RND_W-1:0] a,
                                                   input logic signed [RND_W-1:0] b);
        logic signed [SPAN_W-1:0] d;
        logic signed [SPAN_W-1:0] ae;
        logic signed [SPAN_W-1:0] be;
        ae = a;
        be = b;
        d  = ae - be;
        return d[SPAN_W-1] ? SPAN_W'(-d) : SPAN_W'(d);
    endfunction

    // captured word
    dda_rast_pkg::cmd_t     cmd_reg;
    logic signed [CW-1:0]   sx_reg, sy_reg, ex_reg, ey_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cmd_reg <= in_command;
            sx_reg  <= in_start_x;
            sy_reg  <= in_start_y;
            ex_reg  <= in_end_x;
            ey_reg  <= in_end_y;
        end
    end

    // rounding and spans
    logic signed [RND_W-1:0] rsx_reg, rsy_reg, rex_reg, rey_reg;
    logic signed [CW:0]      dx_reg, dy_reg;
    logic [SPAN_W-1:0]       span_reg;
    logic [NUM_W-1:0]        magx_reg, magy_reg;
    logic                    negx_reg, negy_reg;
    logic [SPAN_W-1:0]       spx, spy;
    logic signed [CW:0]      sxe, sye, exe, eye;

    assign sxe = sx_reg;
    assign sye = sy_reg;
    assign exe = ex_reg;
    assign eye = ey_reg;
    assign spx = abs_diff(rsx_reg, rex_reg);
    assign spy = abs_diff(rsy_reg, rey_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.do_round)
        begin
            rsx_reg <= round_coord(sx_reg);
            rsy_reg <= round_coord(sy_reg);
            rex_reg <= round_coord(ex_reg);
            rey_reg <= round_coord(ey_reg);
            dx_reg  <= exe - sxe;
            dy_reg  <= eye - sye;
        end
        if (cmd.do_span)
        begin
            span_reg <= (spx > spy) ? spx : spy;
            magx_reg <= scale_mag(dx_reg);
            magy_reg <= scale_mag(dy_reg);
            negx_reg <= dx_reg[CW];
            negy_reg <= dy_reg[CW];
        end
    end

    // two restoring dividers sharing one count
    logic [DVD_W-1:0]   dvdx_reg, dvdy_reg, qx_reg, qy_reg;
    logic [SPAN_W-1:0]  remx_reg, remy_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [SPAN_W:0]    remx_t, remy_t, den_e;
    logic               gex, gey;
    logic [SPAN_W:0]    remx_d, remy_d;

    assign den_e  = {1'b0, span_reg};
    assign remx_t = {remx_reg, dvdx_reg[DVD_W-1]};
    assign remy_t = {remy_reg, dvdy_reg[DVD_W-1]};
    assign gex    = remx_t >= den_e;
    assign gey    = remy_t >= den_e;
    assign remx_d = remx_t - den_e;
    assign remy_d = remy_t - den_e;

    always_ff @(posedge clk)
    begin
        if (cmd.do_prep)
        begin
            dvdx_reg <= DVD_W'(magx_reg) + DVD_W'(span_reg >> 1);
            dvdy_reg <= DVD_W'(magy_reg) + DVD_W'(span_reg >> 1);
            remx_reg <= '0;
            remy_reg <= '0;
            qx_reg   <= '0;
            qy_reg   <= '0;
            cnt_reg  <= CNT_TOP;
        end
        else if (cmd.div_step)
        begin
            dvdx_reg <= dvdx_reg << 1;
            dvdy_reg <= dvdy_reg << 1;
            remx_reg <= gex ? remx_d[SPAN_W-1:0] : remx_t[SPAN_W-1:0];
            remy_reg <= gey ? remy_d[SPAN_W-1:0] : remy_t[SPAN_W-1:0];
            qx_reg   <= {qx_reg[DVD_W-2:0], gex};
            qy_reg   <= {qy_reg[DVD_W-2:0], gey};
            cnt_reg  <= cnt_reg - CNT_W'(1);
        end
    end

    // run state
    logic signed [ACC_W-1:0] cur_x_reg, cur_y_reg, step_x_reg, step_y_reg;
    logic [STW-1:0]          steps_left_reg;
    logic                    run_active_reg;
    logic signed [ACC_W-1:0] init_x, init_y, offx_e, offy_e, sclx_e, scly_e;
    logic signed [ACC_W-1:0] qx_e, qy_e;

    assign offx_e = offset_x_reg;
    assign offy_e = offset_y_reg;
    assign sclx_e = scale_coord(sx_reg);
    assign scly_e = scale_coord(sy_reg);
    assign init_x = sclx_e + (offx_e <<< STEP_FRAC_BITS);
    assign init_y = scly_e + (offy_e <<< STEP_FRAC_BITS);
    assign qx_e   = ACC_W'(qx_reg);
    assign qy_e   = ACC_W'(qy_reg);

    // clip test and pixel rounding
    logic signed [ACC_W-1:0] clip_hi, clip_lo, chi_e, clo_e;
    logic                    outside;
    logic signed [ACC_W:0]   cx_e, cy_e, nbx, nby, rx_t, ry_t;
    logic [STW-1:0]          steps_dec;

    assign chi_e   = clip_high_reg;
    assign clo_e   = clip_low_reg;
    assign clip_hi = chi_e <<< STEP_FRAC_BITS;
    assign clip_lo = clo_e <<< STEP_FRAC_BITS;
    assign outside = (cur_x_reg > clip_hi) || (cur_x_reg < clip_lo)
                  || (cur_y_reg > clip_hi) || (cur_y_reg < clip_lo);
    assign cx_e    = cur_x_reg;
    assign cy_e    = cur_y_reg;
    assign nbx     = (ACC_W+1)'(cur_x_reg[ACC_W-1]);
    assign nby     = (ACC_W+1)'(cur_y_reg[ACC_W-1]);
    assign rx_t    = (cx_e + HALF_S - nbx) >>> STEP_FRAC_BITS;
    assign ry_t    = (cy_e + HALF_S - nby) >>> STEP_FRAC_BITS;
    assign steps_dec = steps_left_reg - STW'(1);

    logic signed [SUM_W-1:0] single_x, single_y, rsx_e, rsy_e, ox_s, oy_s;

    assign rsx_e    = rsx_reg;
    assign rsy_e    = rsy_reg;
    assign ox_s     = offset_x_reg;
    assign oy_s     = offset_y_reg;
    assign single_x = rsx_e + ox_s;
    assign single_y = rsy_e + oy_s;

    logic emit_single, emit_load, emit_step;

    assign emit_single = cmd.emit && (cmd.emit_kind == dda_rast_pkg::EMIT_SINGLE);
    assign emit_load   = cmd.emit && (cmd.emit_kind == dda_rast_pkg::EMIT_LOAD);
    assign emit_step   = cmd.emit && (cmd.emit_kind == dda_rast_pkg::EMIT_STEP);

    always_ff @(posedge clk)
    begin
        if (cmd.do_prep)
        begin
            cur_x_reg <= init_x;
            cur_y_reg <= init_y;
        end
        else if (cmd.do_add)
        begin
            cur_x_reg <= cur_x_reg + step_x_reg;
            cur_y_reg <= cur_y_reg + step_y_reg;
        end
        if (emit_load)
        begin
            step_x_reg <= negx_reg ? -qx_e : qx_e;
            step_y_reg <= negy_reg ? -qy_e : qy_e;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_active_reg <= 1'b0;
            steps_left_reg <= '0;
        end
        else if (emit_single)
        begin
            run_active_reg <= 1'b0;
            steps_left_reg <= '0;
        end
        else if (emit_load)
        begin
            run_active_reg <= 1'b1;
            steps_left_reg <= STW'(span_reg);
        end
        else if (emit_step)
        begin
            if (outside)
            begin
                run_active_reg <= 1'b0;
                steps_left_reg <= '0;
            end
            else
            begin
                run_active_reg <= steps_dec != '0;
                steps_left_reg <= steps_dec;
            end
        end
    end

    // output word register
    logic                   out_valid_reg;
    logic                   point_valid_reg, last_reg;
    logic signed [PW-1:0]   pixel_x_reg, pixel_y_reg;
    logic                   res_free;

    assign res_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            case (cmd.emit_kind)
                dda_rast_pkg::EMIT_IDLE:
                begin
                    point_valid_reg <= 1'b0;
                    pixel_x_reg     <= '0;
                    pixel_y_reg     <= '0;
                    last_reg        <= 1'b1;
                end
                dda_rast_pkg::EMIT_SINGLE:
                begin
                    point_valid_reg <= 1'b1;
                    pixel_x_reg     <= single_x[PW-1:0];
                    pixel_y_reg     <= single_y[PW-1:0];
                    last_reg        <= 1'b1;
                end
                dda_rast_pkg::EMIT_LOAD:
                begin
                    point_valid_reg <= 1'b0;
                    pixel_x_reg     <= '0;
                    pixel_y_reg     <= '0;
                    last_reg        <= 1'b0;
                end
                dda_rast_pkg::EMIT_STEP:
                begin
                    point_valid_reg <= !outside;
                    pixel_x_reg     <= outside ? '0 : rx_t[PW-1:0];
                    pixel_y_reg     <= outside ? '0 : ry_t[PW-1:0];
                    last_reg        <= outside || (steps_dec == '0);
                end
                default:
                begin
                    point_valid_reg <= 1'b0;
                    pixel_x_reg     <= '0;
                    pixel_y_reg     <= '0;
                    last_reg        <= 1'b1;
                end
            endcase
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_point_valid = point_valid_reg;
    assign out_pixel_x     = pixel_x_reg;
    assign out_pixel_y     = pixel_y_reg;
    assign out_last        = last_reg;

    assign stat.is_advance = cmd_reg == dda_rast_pkg::CMD_ADVANCE;
    assign stat.run_active = run_active_reg;
    assign stat.span_zero  = span_reg == '0;
    assign stat.div_last   = cnt_reg == '0;
    assign stat.res_free   = res_free;

endmodule

FILE: rtl/dda_line_rasterizer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DDA line rasteriser
// Usage:
//   line_in   : valid/ready words. command LOAD takes a segment (fixed-point
//               end points), command ADVANCE steps the active run once.
//   pixel_out : one result word per input word, in order: point_valid,
//               pixel_x, pixel_y, last.
//   cfg       : register writes (offset_x, offset_y, clip_high, clip_low),
//               always ready; write only while the block is idle.
//   Timing: an ADVANCE word passes through capture, dispatch, accumulate and
//   clip/round, and its result is then registered. A LOAD of a multi-point
//   segment passes through capture, dispatch, rounding, span, divider set-up,
//   the bit-per-cycle shift-subtract dividers for both axes, and issue; a
//   one-point LOAD skips the dividers. One word is in work at a time.
//   A finished word waits in the output register while the next input is
//   taken; if the receiver stalls, the controller holds in its last state
//   until the output register frees.
//   Reset: idle, no run active, registers at their reset values, output empty.
// ----------------------------------------------------------------------------
module dda_line_rasterizer_unit
#(
    parameter int COORD_FRAC_BITS = dda_rast_pkg::DEF_COORD_FRAC_BITS,
    parameter int STEP_FRAC_BITS  = dda_rast_pkg::DEF_STEP_FRAC_BITS
)
(
    input  logic                clk,
    input  logic                rst_n,
    dda_rast_in_if.sink         line_in,
    dda_rast_out_if.source      pixel_out,
    dda_rast_cfg_if.sink        cfg
);

    dda_rast_pkg::dp_cmd_t  cmd;
    dda_rast_pkg::dp_stat_t stat;

    assign cfg.ready = 1'b1;

    dda_rast_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (line_in.valid),
        .in_ready (line_in.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    dda_rast_dp
    #(
        .COORD_FRAC_BITS (COORD_FRAC_BITS),
        .STEP_FRAC_BITS  (STEP_FRAC_BITS)
    )
    u_dp
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .cfg_we          (cfg.valid),
        .cfg_index       (cfg.index),
        .cfg_data        (cfg.data),
        .in_command      (line_in.command),
        .in_start_x      (line_in.start_x),
        .in_start_y      (line_in.start_y),
        .in_end_x        (line_in.end_x),
        .in_end_y        (line_in.end_y),
        .out_ready       (pixel_out.ready),
        .out_valid       (pixel_out.valid),
        .out_point_valid (pixel_out.point_valid),
        .out_pixel_x     (pixel_out.pixel_x),
        .out_pixel_y     (pixel_out.pixel_y),
        .out_last        (pixel_out.last)
    );

endmodule
